### rtl/core/quicksort_middle_pivot_defines.svh
// Assertion macros used by the checker of the sort block.
`ifndef QUICKSORT_MIDDLE_PIVOT_DEFINES_SVH
`define QUICKSORT_MIDDLE_PIVOT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define QS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qsmp check failed");

// next-cycle implication, disabled while reset is asserted
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qsmp check failed");

`endif

### rtl/core/qsmp_pkg.sv
package qsmp_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int DATA_W        = 32;
	localparam int CNT_W         = 16;

	localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

	typedef logic [CNT_W-1:0] cnt_t;

	// saturating counter step
	function automatic cnt_t sat_add(input cnt_t a, input logic [1:0] k);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W-1){1'b0}}, k};
		return s[CNT_W] ? CNT_SAT : s[CNT_W-1:0];
	endfunction

endpackage

### rtl/core/quicksort_middle_pivot.sv
// Channel   Direction  Handshake                 Payload
// input     in         start / busy              data_value, last_item
// result    out        strobe (one cycle)        sorted_value, last_result,
//                                                comparisons_made, assignments_made
//
// Loading takes one cycle per word; busy stays low between words.
// The word flagged last starts the sort: each partition pops its range, reads range and
// pivot, scans from both ends and swaps, pushes the subranges; a final pop ends the sort.
// Emission follows at one word per cycle, n words; busy drops with the last one.
// Reset clears control state only; the store needs no clearing pass.
// The receiver cannot stall; results are presented for exactly one cycle.
module quicksort_middle_pivot #(
	parameter int MAX_ITEMS = qsmp_pkg::MAX_ITEMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [qsmp_pkg::DATA_W-1:0] data_value,
	input  logic                               last_item,
	output logic                               strobe,
	output logic signed [qsmp_pkg::DATA_W-1:0] sorted_value,
	output logic                               last_result,
	output logic        [qsmp_pkg::CNT_W-1:0]  comparisons_made,
	output logic        [qsmp_pkg::CNT_W-1:0]  assignments_made
);

	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = AW + 1;
	localparam int XW  = AW + 2;
	localparam int DW  = qsmp_pkg::DATA_W;
	localparam int SEW = 2 * AW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_POP   = 4'd1;
	localparam logic [3:0] S_RNG   = 4'd2;
	localparam logic [3:0] S_PIV   = 4'd3;
	localparam logic [3:0] S_SCANI = 4'd4;
	localparam logic [3:0] S_SCANJ = 4'd5;
	localparam logic [3:0] S_SWAP  = 4'd6;
	localparam logic [3:0] S_PUSHA = 4'd7;
	localparam logic [3:0] S_PUSHB = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;

	localparam logic signed [XW-1:0] ONE_X = XW'(1);

	logic [3:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       sp_q;
	logic [AW-1:0]       lo_q, hi_q, k_q;
	logic signed [XW-1:0] i_q, j_q;
	logic [DW-1:0]       pivot_q, a_q;
	qsmp_pkg::cnt_t      cmp_q, asg_q;
	logic                emit_vld_q, emit_last_q;

	logic [DW-1:0]  st_mem [MAX_ITEMS];
	logic [DW-1:0]  st_rd_q;
	logic [SEW-1:0] stk_mem [MAX_ITEMS];
	logic [SEW-1:0] stk_rd_q;

	logic           st_we, stk_we;
	logic [AW-1:0]  st_waddr, st_raddr, stk_waddr, stk_raddr;
	logic [DW-1:0]  st_wdata;
	logic [SEW-1:0] stk_wdata;

	logic           accept;
	logic           room;
	logic [AW:0]    mid_sum;
	logic [AW-1:0]  first_hi;
	logic signed [XW-1:0] i_inc, j_dec, lo_x, hi_x;
	logic           lt_i, lt_j, emit_end;

	assign accept   = start && (state_q == S_IDLE);
	assign room     = cnt_q < CW'(MAX_ITEMS);
	assign first_hi = room ? cnt_q[AW-1:0] : AW'(cnt_q - CW'(1));
	assign mid_sum  = {1'b0, stk_rd_q[SEW-1:AW]} + {1'b0, stk_rd_q[AW-1:0]};
	assign i_inc    = i_q + ONE_X;
	assign j_dec    = j_q - ONE_X;
	assign lo_x     = $signed({2'b00, lo_q});
	assign hi_x     = $signed({2'b00, hi_q});
	assign lt_i     = $signed(st_rd_q) < $signed(pivot_q);
	assign lt_j     = $signed(pivot_q) < $signed(st_rd_q);
	assign emit_end = {1'b0, k_q} == (cnt_q - CW'(1));

	always_comb begin
		st_we     = 1'b0;
		st_waddr  = cnt_q[AW-1:0];
		st_wdata  = data_value;
		st_raddr  = i_q[AW-1:0];
		stk_we    = 1'b0;
		stk_waddr = sp_q[AW-1:0];
		stk_wdata = {{AW{1'b0}}, first_hi};
		stk_raddr = AW'(sp_q - CW'(1));
		case (state_q)
			S_IDLE: begin
				st_we = accept && room;
				// first range goes on the stack with the last word
				stk_we    = accept && last_item;
				stk_waddr = '0;
			end
			S_RNG: st_raddr = mid_sum[AW:1];
			S_SCANI: st_raddr = (lt_i && (i_q[AW-1:0] < hi_q)) ? i_inc[AW-1:0] : j_q[AW-1:0];
			S_SCANJ: begin
				st_raddr = j_dec[AW-1:0];
				st_we    = !(lt_j && (j_q[AW-1:0] > lo_q)) && (i_q <= j_q);
				st_waddr = i_q[AW-1:0];
				st_wdata = st_rd_q;
			end
			S_SWAP: begin
				st_raddr = i_inc[AW-1:0];
				st_we    = 1'b1;
				st_waddr = j_q[AW-1:0];
				st_wdata = a_q;
			end
			S_PUSHA: begin
				stk_we    = i_q < hi_x;
				stk_wdata = {i_q[AW-1:0], hi_q};
			end
			S_PUSHB: begin
				stk_we    = lo_x < j_q;
				stk_wdata = {lo_q, j_q[AW-1:0]};
			end
			S_EMIT: st_raddr = k_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		st_rd_q <= st_mem[st_raddr];
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sp_q        <= '0;
			k_q         <= '0;
			cmp_q       <= '0;
			asg_q       <= '0;
			emit_vld_q  <= 1'b0;
			emit_last_q <= 1'b0;
		end else begin
			emit_vld_q  <= state_q == S_EMIT;
			emit_last_q <= (state_q == S_EMIT) && emit_end;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (last_item) begin
							sp_q    <= CW'(1);
							cmp_q   <= '0;
							asg_q   <= '0;
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						sp_q    <= sp_q - CW'(1);
						state_q <= S_RNG;
					end
				end
				S_RNG: begin
					lo_q    <= stk_rd_q[SEW-1:AW];
					hi_q    <= stk_rd_q[AW-1:0];
					i_q     <= $signed({2'b00, stk_rd_q[SEW-1:AW]});
					j_q     <= $signed({2'b00, stk_rd_q[AW-1:0]});
					asg_q   <= qsmp_pkg::sat_add(asg_q, 2'd1);
					state_q <= S_PIV;
				end
				S_PIV: begin
					pivot_q <= st_rd_q;
					state_q <= S_SCANI;
				end
				S_SCANI: begin
					cmp_q <= qsmp_pkg::sat_add(cmp_q, 2'd1);
					if (lt_i && (i_q[AW-1:0] < hi_q)) begin
						i_q <= i_inc;
					end else begin
						a_q     <= st_rd_q;
						state_q <= S_SCANJ;
					end
				end
				S_SCANJ: begin
					cmp_q <= qsmp_pkg::sat_add(cmp_q, 2'd1);
					if (lt_j && (j_q[AW-1:0] > lo_q)) begin
						j_q <= j_dec;
					end else if (i_q <= j_q) begin
						asg_q   <= qsmp_pkg::sat_add(asg_q, 2'd3);
						state_q <= S_SWAP;
					end else begin
						state_q <= S_PUSHA;
					end
				end
				S_SWAP: begin
					i_q     <= i_inc;
					j_q     <= j_dec;
					state_q <= (i_inc <= j_dec) ? S_SCANI : S_PUSHA;
				end
				S_PUSHA: begin
					if (i_q < hi_x) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= S_PUSHB;
				end
				S_PUSHB: begin
					if (lo_x < j_q) begin
						sp_q <= sp_q + CW'(1);
					end
					state_q <= S_POP;
				end
				S_EMIT: begin
					k_q <= k_q + AW'(1);
					if (emit_end) begin
						cnt_q   <= '0;
						sp_q    <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy             = state_q != S_IDLE;
	assign strobe           = emit_vld_q;
	assign last_result      = emit_last_q;
	assign sorted_value     = $signed(st_rd_q);
	assign comparisons_made = cmp_q;
	assign assignments_made = asg_q;

endmodule

### rtl/core/qsmp_check.sv
`include "quicksort_middle_pivot_defines.svh"

module qsmp_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic signed [qsmp_pkg::DATA_W-1:0] data_value,
	input logic                               last_item,
	input logic                               strobe,
	input logic signed [qsmp_pkg::DATA_W-1:0] sorted_value,
	input logic                               last_result,
	input logic        [qsmp_pkg::CNT_W-1:0]  comparisons_made,
	input logic        [qsmp_pkg::CNT_W-1:0]  assignments_made
);

	logic pay_seen;
	assign pay_seen = ^{data_value, sorted_value} | 1'b1;

	// only the final word of a run may show while idle
	`QS_ASSERT_NOW(a_mid_run_busy, clk, arst_n, strobe && !last_result && pay_seen, busy)
	// a run ends after its final word
	`QS_ASSERT_NEXT(a_last_ends, clk, arst_n, strobe && last_result, !strobe)
	// a word not flagged last leaves the block idle
	`QS_ASSERT_NEXT(a_load_idle, clk, arst_n, start && !busy && !last_item, !busy && !strobe)
	// the final word starts the sort
	`QS_ASSERT_NEXT(a_sort_busy, clk, arst_n, start && !busy && last_item, busy)
	// run totals hold across the emitted words
	`QS_ASSERT_NOW(a_totals_hold, clk, arst_n, strobe && $past(strobe),
		$stable(comparisons_made) && $stable(assignments_made))

endmodule

bind quicksort_middle_pivot qsmp_check u_qsmp_check (.*);

### sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH   = 64;
	localparam int RANDOM_WORDS  = 80;
	localparam int STALL_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 40;
	localparam int SHOWN_ERRORS  = 10;

	typedef logic signed [qsmp_pkg::DATA_W-1:0] word_t;

	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7fff_ffff;

	typedef enum int {VALS_WIDE, VALS_DUPS, VALS_EDGE} value_mix_t;

	typedef struct {
		word_t          value;
		logic           last;
		qsmp_pkg::cnt_t compares;
		qsmp_pkg::cnt_t moves;
	} sorted_word_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	word_t data_value = '0;
	logic  last_item = 1'b0;
	logic  busy;
	logic  strobe;
	word_t sorted_value;
	logic  last_result;
	qsmp_pkg::cnt_t comparisons_made;
	qsmp_pkg::cnt_t assignments_made;

	word_t        loaded_words[$];
	sorted_word_t expected_words[$];

	int  errors = 0;
	int  words_sent = 0;
	int  runs_sorted = 0;
	int  longest_run = 0;
	int  results_checked = 0;
	int  stall_cycles = 0;
	bit  gaps_on = 1'b1;

	quicksort_middle_pivot u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.data_value       (data_value),
		.last_item        (last_item),
		.strobe           (strobe),
		.sorted_value     (sorted_value),
		.last_result      (last_result),
		.comparisons_made (comparisons_made),
		.assignments_made (assignments_made)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic qsmp_pkg::cnt_t count_up(input qsmp_pkg::cnt_t c, input int k);
		int s;
		s = int'(c) + k;
		return (s > 65535) ? qsmp_pkg::cnt_t'(65535) : qsmp_pkg::cnt_t'(s);
	endfunction

	// Hoare partition around the middle element, pending ranges on a stack;
	// queues the whole ascending output of the run.
	function automatic void sort_loaded_words();
		word_t          arr[STORE_DEPTH];
		logic [11:0]    ranges[STORE_DEPTH];
		logic [11:0]    top;
		word_t          pivot;
		word_t          t;
		qsmp_pkg::cnt_t n_cmp;
		qsmp_pkg::cnt_t n_asg;
		sorted_word_t   w;
		int             n, depth, lo, hi, i, j;
		n = loaded_words.size();
		for (int k = 0; k < n; k++)
			arr[k] = loaded_words[k];
		n_cmp = '0;
		n_asg = '0;
		ranges[0] = {6'd0, 6'(n - 1)};
		depth = 1;
		while (depth > 0) begin
			depth--;
			top = ranges[depth];
			lo = int'(top[11:6]);
			hi = int'(top[5:0]);
			i = lo;
			j = hi;
			pivot = arr[(lo + hi) / 2];
			n_asg = count_up(n_asg, 1);
			while (i <= j) begin
				n_cmp = count_up(n_cmp, 1);
				while (arr[i] < pivot && i < hi) begin
					i++;
					n_cmp = count_up(n_cmp, 1);
				end
				n_cmp = count_up(n_cmp, 1);
				while (pivot < arr[j] && j > lo) begin
					j--;
					n_cmp = count_up(n_cmp, 1);
				end
				if (i <= j) begin
					t = arr[i];
					arr[i] = arr[j];
					arr[j] = t;
					n_asg = count_up(n_asg, 3);
					i++;
					j--;
				end
			end
			if (i < hi && depth < STORE_DEPTH) begin
				ranges[depth] = {6'(i), 6'(hi)};
				depth++;
			end
			if (lo < j && depth < STORE_DEPTH) begin
				ranges[depth] = {6'(lo), 6'(j)};
				depth++;
			end
		end
		for (int k = 0; k < n; k++) begin
			w.value    = arr[k];
			w.last     = (k == n - 1);
			w.compares = n_cmp;
			w.moves    = n_asg;
			expected_words.push_back(w);
		end
		runs_sorted++;
		if (n > longest_run)
			longest_run = n;
		loaded_words.delete();
	endfunction

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic word_t pick_value(input value_mix_t mix);
		case (mix)
			VALS_DUPS: begin
				return word_t'($urandom_range(0, 6)) - 3;
			end
			VALS_EDGE: begin
				case ($urandom_range(0, 4))
					0: return WORD_MIN;
					1: return WORD_MAX;
					2: return word_t'(0);
					3: return word_t'(-1);
					default: return word_t'($urandom);
				endcase
			end
			default: begin
				return word_t'($urandom);
			end
		endcase
	endfunction

	// holds start until the word is taken; start is left high for the caller
	task automatic send_word(input word_t v, input logic last);
		@(negedge clk);
		start      <= 1'b1;
		data_value <= v;
		last_item  <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
		if (loaded_words.size() < STORE_DEPTH)
			loaded_words.push_back(v);
		if (last)
			sort_loaded_words();
	endtask

	task automatic sender_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 10)) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_run(input int len, input value_mix_t mix);
		for (int k = 0; k < len; k++) begin
			sender_gap();
			send_word(pick_value(mix), k == len - 1);
		end
	endtask

	task automatic test_tiny_runs();
		send_word(WORD_MIN, 1'b1);
		send_word(WORD_MAX, 1'b1);
		send_word(word_t'(0), 1'b1);
		send_word(WORD_MAX, 1'b0);
		send_word(WORD_MIN, 1'b1);
		send_word(word_t'(5), 1'b0);
		send_word(word_t'(5), 1'b1);
	endtask

	task automatic test_extremes();
		send_word(WORD_MIN, 1'b0);
		send_word(WORD_MAX, 1'b0);
		send_word(word_t'(0), 1'b0);
		send_word(word_t'(-1), 1'b0);
		send_word(word_t'(1), 1'b0);
		send_word(WORD_MAX, 1'b0);
		send_word(WORD_MIN, 1'b0);
		send_word(word_t'(32'h5555_5555), 1'b0);
		send_word(word_t'(32'haaaa_aaaa), 1'b1);
		// already ascending, then descending
		for (int k = 0; k < 5; k++)
			send_word(word_t'(k * 7 - 10), k == 4);
		for (int k = 0; k < 5; k++)
			send_word(word_t'(100 - k * 30), k == 4);
	endtask

	// the flagged word is the one that fills the store exactly
	task automatic test_store_full();
		send_run(STORE_DEPTH, VALS_WIDE);
		wait_drained();
	endtask

	// words past a full store are dropped; the flagged one still sorts
	task automatic test_overflow();
		for (int k = 0; k < STORE_DEPTH; k++) begin
			sender_gap();
			send_word(pick_value(VALS_DUPS), 1'b0);
		end
		send_word(WORD_MIN, 1'b0);
		send_word(WORD_MAX, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_runs();
		int sent;
		int len;
		int r;
		value_mix_t mix;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 19);
			if (r < 16)
				len = $urandom_range(1, 12);
			else if (r < 19)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(41, STORE_DEPTH);
			r = $urandom_range(0, 19);
			if (r < 12)
				mix = VALS_WIDE;
			else if (r < 17)
				mix = VALS_DUPS;
			else
				mix = VALS_EDGE;
			send_run(len, mix);
			sent += len;
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		for (int k = 0; k < 6; k++)
			send_run($urandom_range(1, 8), value_mix_t'($urandom_range(0, 2)));
	endtask

	always @(posedge clk) begin
		sorted_word_t want;
		if (arst_n && strobe) begin
			if (expected_words.size() == 0) begin
				note_error($sformatf("unexpected word %0d last %0b cmp %0d asg %0d",
					sorted_value, last_result, comparisons_made, assignments_made));
			end else begin
				want = expected_words.pop_front();
				results_checked++;
				if (sorted_value !== want.value || last_result !== want.last ||
				    comparisons_made !== want.compares || assignments_made !== want.moves)
					note_error($sformatf(
						"got %0d/%0b/%0d/%0d expected %0d/%0b/%0d/%0d (value/last/cmp/asg)",
						sorted_value, last_result, comparisons_made, assignments_made,
						want.value, want.last, want.compares, want.moves));
			end
		end
	end

	// no accepted word in either direction for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** quicksort_middle_pivot: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_tiny_runs();
		test_extremes();
		wait_drained();
		test_store_full();
		test_overflow();
		test_random_runs();
		test_back_to_back();
		@(negedge clk);
		start <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			note_error($sformatf("%0d words never arrived", expected_words.size()));
		$display("Sorted %0d runs from %0d words sent (longest run %0d, store overflow included);",
			runs_sorted, words_sent, longest_run);
		$display("%0d sorted words checked, %0d errors.", results_checked, errors);
		if (errors == 0) begin
			$display("** quicksort_middle_pivot: PASSED **");
		end else begin
			$display("** quicksort_middle_pivot: FAILED **");
		end
		$finish;
	end

endmodule

### quicksort_middle_pivot.f
+incdir+rtl/core
rtl/core/qsmp_pkg.sv
rtl/core/quicksort_middle_pivot.sv
rtl/core/qsmp_check.sv
sim/tb_top.sv
